@@ rtl/core/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants for the byte-budget object cache table: field
// widths, register indexes, reset values, the entry row layout, the shared
// arithmetic unit interface and the sequencer states.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int KEY_W     = 64;
  localparam int SIZE_W    = 24;
  localparam int STAMP_W   = 32;
  localparam int SLOT_W    = 4;
  localparam int EVICT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int OPND_W    = 64;

  localparam logic [SIZE_W-1:0]  CAP_RESET    = 24'd1049000;
  localparam logic [SIZE_W-1:0]  MAXOBJ_RESET = 24'd102400;
  localparam logic [EVICT_W-1:0] EVICT_MAX    = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OBJECT = 1'd1;

  // one stored object
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SIZE_W-1:0]  bytes;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // shared arithmetic unit
  typedef enum logic {
    CMP_SUB,
    CMP_ADD_SAT
  } cmp_op_t;

  typedef struct packed {
    cmp_op_t           op;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic              eq;
    logic              borrow;
    logic [SIZE_W-1:0] res;
  } cmp_rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_COND,
    S_EVSCAN,
    S_EVICT,
    S_FIT,
    S_FREE,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/byte_budget_object_cache_table_unit.sv @@
// ----------------------------------------------------------------------------
// byte_budget_object_cache_table_unit
// Object cache table with a byte budget and oldest-inserted-first eviction.
// Lookups scan all slots for the lowest slot with a matching key; inserts
// evict the oldest entries as needed and store the object in the first free slot.
// ----------------------------------------------------------------------------
// Lookup: one slot read a cycle, then the result goes to the output register.
// Insert: refused above the object limit or if the object does not fit after
//   eviction; each eviction is a full stamp scan of the store.
// One item at a time; a new item is taken while the previous result waits.
// Reset empties the table, sets free bytes to the capacity reset value and
//   clears the stamp counter; a capacity write also empties the table.
module byte_budget_object_cache_table_unit
  import bbc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic [KEY_W-1:0]     key,
  input  logic [SIZE_W-1:0]    object_size,
  // result items
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [SLOT_W-1:0]    slot,
  output logic                 stored,
  output logic [EVICT_W-1:0]   evictions,
  output logic [SIZE_W-1:0]    free_bytes,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_t               state, state_next;
  logic [CW-1:0]        idx, idx_next;
  logic [CW-1:0]        count, count_next;
  logic [ENTRIES-1:0]   valid, valid_next;
  logic [KEY_W-1:0]     key_q, key_q_next;
  logic [SIZE_W-1:0]    size_q, size_q_next;
  logic [SIZE_W-1:0]    max_obj, max_obj_next;
  logic [SIZE_W-1:0]    bytes_free, bytes_free_next;
  logic [STAMP_W-1:0]   insert_counter, insert_counter_next;
  logic [STAMP_W-1:0]   best_stamp, best_stamp_next;
  logic [SW-1:0]        pick, pick_next;
  logic [SIZE_W-1:0]    pick_bytes, pick_bytes_next;
  logic                 have_pick, have_pick_next;
  logic                 found, found_next;
  logic [SW-1:0]        slot_q, slot_q_next;
  logic                 stored_q, stored_q_next;
  logic [EVICT_W-1:0]   evict_cnt, evict_cnt_next;
  logic                 out_valid_next;
  logic                 hit_next;
  logic [SLOT_W-1:0]    slot_next;
  logic                 stored_next;
  logic [EVICT_W-1:0]   evictions_next;
  logic [SIZE_W-1:0]    free_bytes_next;

  logic [SW-1:0]        pidx;
  logic                 mem_we;
  logic [SW-1:0]        mem_waddr;
  entry_t               mem_wdata;
  entry_t               mem_rdata;
  cmp_req_t             cmp_req;
  cmp_rsp_t             cmp_rsp;

  // entry store
  bbc_entry_mem #(
    .ENTRIES (ENTRIES),
    .SW      (SW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx[SW-1:0]),
    .rdata (mem_rdata)
  );

  // shared arithmetic unit
  bbc_cmp_unit u_cmp (
    .req (cmp_req),
    .rsp (cmp_rsp)
  );

  // slot whose read data is present this cycle
  assign pidx = SW'(idx - CW'(1));

  // sequencer: next state, datapath control and config writes
  always_comb begin
    state_next          = state;
    idx_next            = idx;
    count_next          = count;
    valid_next          = valid;
    key_q_next          = key_q;
    size_q_next         = size_q;
    max_obj_next        = max_obj;
    bytes_free_next     = bytes_free;
    insert_counter_next = insert_counter;
    best_stamp_next     = best_stamp;
    pick_next           = pick;
    pick_bytes_next     = pick_bytes;
    have_pick_next      = have_pick;
    found_next          = found;
    slot_q_next         = slot_q;
    stored_q_next       = stored_q;
    evict_cnt_next      = evict_cnt;
    out_valid_next      = out_valid && !out_ready;
    hit_next            = hit;
    slot_next           = slot;
    stored_next         = stored;
    evictions_next      = evictions;
    free_bytes_next     = free_bytes;
    in_ready            = (state == S_IDLE);
    mem_we              = 1'b0;
    mem_waddr           = pick;
    mem_wdata.key       = key_q;
    mem_wdata.bytes     = size_q;
    mem_wdata.stamp     = insert_counter + STAMP_W'(1);
    cmp_req.op          = CMP_SUB;
    cmp_req.a           = '0;
    cmp_req.b           = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_q_next     = key;
          size_q_next    = object_size;
          found_next     = 1'b0;
          slot_q_next    = '0;
          stored_q_next  = 1'b0;
          evict_cnt_next = '0;
          idx_next       = '0;
          state_next     = mode ? S_CHECK : S_LOOK;
        end
      end

      // key scan, lowest matching slot wins
      S_LOOK: begin
        cmp_req.a = mem_rdata.key;
        cmp_req.b = key_q;
        if ((idx != '0) && !found && valid[pidx] && cmp_rsp.eq) begin
          found_next  = 1'b1;
          slot_q_next = pidx;
        end
        if (idx == CW'(ENTRIES)) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx + CW'(1);
        end
      end

      // refuse objects above the per-object limit
      S_CHECK: begin
        cmp_req.a = OPND_W'(max_obj);
        cmp_req.b = OPND_W'(size_q);
        state_next = cmp_rsp.borrow ? S_DONE : S_COND;
      end

      // evict while short of the free-space target or full
      S_COND: begin
        cmp_req.a = OPND_W'(bytes_free);
        cmp_req.b = OPND_W'(max_obj);
        if ((cmp_rsp.borrow || (count >= CW'(ENTRIES))) && (count != '0)) begin
          idx_next       = '0;
          have_pick_next = 1'b0;
          state_next     = S_EVSCAN;
        end else begin
          state_next = S_FIT;
        end
      end

      // oldest stamp scan, ties to the lowest slot
      S_EVSCAN: begin
        cmp_req.a = OPND_W'(mem_rdata.stamp);
        cmp_req.b = OPND_W'(best_stamp);
        if ((idx != '0) && valid[pidx] && (!have_pick || cmp_rsp.borrow)) begin
          best_stamp_next = mem_rdata.stamp;
          pick_next       = pidx;
          pick_bytes_next = mem_rdata.bytes;
          have_pick_next  = 1'b1;
        end
        if (idx == CW'(ENTRIES)) begin
          state_next = S_EVICT;
        end else begin
          idx_next = idx + CW'(1);
        end
      end

      // return the victim's bytes to the budget
      S_EVICT: begin
        cmp_req.op        = CMP_ADD_SAT;
        cmp_req.a         = OPND_W'(bytes_free);
        cmp_req.b         = OPND_W'(pick_bytes);
        bytes_free_next   = cmp_rsp.res;
        valid_next[pick]  = 1'b0;
        count_next        = count - CW'(1);
        if (evict_cnt != EVICT_MAX) begin
          evict_cnt_next = evict_cnt + EVICT_W'(1);
        end
        state_next = S_COND;
      end

      // object must fit in what is free now
      S_FIT: begin
        cmp_req.a = OPND_W'(bytes_free);
        cmp_req.b = OPND_W'(size_q);
        if (cmp_rsp.borrow) begin
          state_next = S_DONE;
        end else begin
          idx_next   = '0;
          state_next = S_FREE;
        end
      end

      // first free slot search
      S_FREE: begin
        if (!valid[idx[SW-1:0]]) begin
          pick_next  = idx[SW-1:0];
          state_next = S_WRITE;
        end else begin
          idx_next = idx + CW'(1);
        end
      end

      // store the object and charge the budget
      S_WRITE: begin
        cmp_req.a           = OPND_W'(bytes_free);
        cmp_req.b           = OPND_W'(size_q);
        bytes_free_next     = cmp_rsp.res;
        mem_we              = 1'b1;
        valid_next[pick]    = 1'b1;
        count_next          = count + CW'(1);
        insert_counter_next = insert_counter + STAMP_W'(1);
        stored_q_next       = 1'b1;
        slot_q_next         = pick;
        state_next          = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          hit_next        = found;
          slot_next       = SLOT_W'(slot_q);
          stored_next     = stored_q;
          evictions_next  = evict_cnt;
          free_bytes_next = bytes_free;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY: begin
          valid_next      = '0;
          count_next      = '0;
          bytes_free_next = cfg_data;
        end
        REG_MAX_OBJECT: begin
          max_obj_next = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      valid          <= '0;
      count          <= '0;
      max_obj        <= MAXOBJ_RESET;
      bytes_free     <= CAP_RESET;
      insert_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      valid          <= valid_next;
      count          <= count_next;
      max_obj        <= max_obj_next;
      bytes_free     <= bytes_free_next;
      insert_counter <= insert_counter_next;
      out_valid      <= out_valid_next;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    key_q      <= key_q_next;
    size_q     <= size_q_next;
    best_stamp <= best_stamp_next;
    pick       <= pick_next;
    pick_bytes <= pick_bytes_next;
    have_pick  <= have_pick_next;
    found      <= found_next;
    slot_q     <= slot_q_next;
    stored_q   <= stored_q_next;
    evict_cnt  <= evict_cnt_next;
    hit        <= hit_next;
    slot       <= slot_next;
    stored     <= stored_next;
    evictions  <= evictions_next;
    free_bytes <= free_bytes_next;
  end

  // entry count tracks the valid bits
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("entry count does not match valid bits");

  // free slot search only runs with room in the table
  a_free_slot_exists: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE) |-> (count < CW'(ENTRIES)))
    else $error("free slot search with a full table");

  // a store adds exactly one entry
  a_write_adds_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> (count == $past(count) + CW'(1)))
    else $error("store did not add one entry");

  // an insert result never reports a lookup hit
  a_hit_excludes_store: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && stored))
    else $error("result reports hit and store together");

  // eviction only starts with a victim available
  a_evict_has_victim: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT) |-> (have_pick && valid[pick]))
    else $error("eviction without a valid victim");

endmodule

@@ rtl/core/bbc_entry_mem.sv @@
// ----------------------------------------------------------------------------
// bbc_entry_mem
// Entry store: key, byte size and insertion stamp of each slot. One write
// port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbc_entry_mem
  import bbc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int SW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [SW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [SW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bbc_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// bbc_cmp_unit
// Shared arithmetic unit: one wide adder that subtracts with borrow out or
// adds with saturation to the byte field, plus an equality compare.
// ----------------------------------------------------------------------------
module bbc_cmp_unit
  import bbc_pkg::*;
(
  input  cmp_req_t req,
  output cmp_rsp_t rsp
);

  logic            sub;
  logic [OPND_W:0] sum;

  // single adder, b inverted for subtraction
  always_comb begin
    sub = (req.op == CMP_SUB);
    sum = {1'b0, req.a} + {1'b0, (sub ? ~req.b : req.b)} + {{OPND_W{1'b0}}, sub};
  end

  // result selection
  always_comb begin
    rsp.eq     = (req.a == req.b);
    rsp.borrow = ~sum[OPND_W];
    if (!sub && (|sum[OPND_W:SIZE_W])) begin
      rsp.res = '1;
    end else begin
      rsp.res = sum[SIZE_W-1:0];
    end
  end

endmodule

@@ test/tb_byte_budget_object_cache_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_budget_object_cache_table_unit
// Self-checking bench for the byte-budget object cache table. A queue-fed
// driver offers lookups and inserts, a monitor checks every result item
// against a local model of the table, budget and stamp counter. The run walks
// through several budget settings, including the extremes, with random idling
// on both channels, a long result stall and a full drain mid-phase.
// ----------------------------------------------------------------------------
module tb_byte_budget_object_cache_table_unit;
  import bbc_pkg::*;

  localparam int ENTRIES         = ENTRIES_DEF;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int KEY_POOL_SIZE   = 20;

  localparam logic              MODE_LOOKUP = 1'b0;
  localparam logic              MODE_INSERT = 1'b1;
  localparam logic [SIZE_W-1:0] SIZE_MAX    = '1;

  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } cache_req_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               stored;
    logic [EVICT_W-1:0] evictions;
    logic [SIZE_W-1:0]  free_bytes;
  } cache_result_t;

  // dut signals
  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic                 mode        = MODE_LOOKUP;
  logic [KEY_W-1:0]     key         = '0;
  logic [SIZE_W-1:0]    object_size = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic                 hit;
  logic [SLOT_W-1:0]    slot;
  logic                 stored;
  logic [EVICT_W-1:0]   evictions;
  logic [SIZE_W-1:0]    free_bytes;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_CAPACITY;
  logic [SIZE_W-1:0]    cfg_data    = '0;

  // bench state
  cache_req_t    pending_reqs[$];
  cache_result_t expected_results[$];
  cache_result_t want_res;
  logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];
  int            failures      = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_left     = 0;
  int            cycle_count   = 0;
  logic          hold_start    = 1'b0;

  // table model
  logic              mdl_valid[ENTRIES];
  logic [KEY_W-1:0]  mdl_key[ENTRIES];
  logic [SIZE_W-1:0] mdl_bytes[ENTRIES];
  logic [31:0]       mdl_stamp[ENTRIES];
  int                mdl_count;
  logic [SIZE_W-1:0] mdl_free;
  logic [31:0]       mdl_inserts;
  logic [SIZE_W-1:0] mdl_capacity;
  logic [SIZE_W-1:0] mdl_max_obj;

  byte_budget_object_cache_table_unit #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .key        (key),
    .object_size(object_size),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .slot       (slot),
    .stored     (stored),
    .evictions  (evictions),
    .free_bytes (free_bytes),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // empty the table and refill the budget
  function automatic void clear_cache_model();
    for (int i = 0; i < ENTRIES; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_key[i]   = '0;
      mdl_bytes[i] = '0;
      mdl_stamp[i] = '0;
    end
    mdl_count = 0;
    mdl_free  = mdl_capacity;
  endfunction

  // expected result of one item, updating the table model
  function automatic cache_result_t predict_cache_result(cache_req_t req);
    cache_result_t res;
    int            pick;
    int            n_evict;
    logic          found;
    logic          stop;
    logic [SIZE_W:0] sum;
    res     = '0;
    n_evict = 0;
    found   = 1'b0;
    stop    = 1'b0;
    if (req.mode == MODE_LOOKUP) begin
      // lowest matching valid slot
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && mdl_valid[i] && mdl_key[i] == req.key) begin
          found    = 1'b1;
          res.hit  = 1'b1;
          res.slot = i[SLOT_W-1:0];
        end
      end
    end else if (req.size <= mdl_max_obj) begin
      // evict oldest while the budget is short or the table is full
      while (!stop && (mdl_free < mdl_max_obj || mdl_count >= ENTRIES)) begin
        pick = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (mdl_valid[i] && (pick < 0 || mdl_stamp[i] < mdl_stamp[pick])) pick = i;
        end
        if (pick < 0) begin
          stop = 1'b1;
        end else begin
          sum = {1'b0, mdl_free} + {1'b0, mdl_bytes[pick]};
          mdl_free = sum[SIZE_W] ? SIZE_MAX : sum[SIZE_W-1:0];
          mdl_valid[pick] = 1'b0;
          if (mdl_count > 0) mdl_count--;
          n_evict++;
        end
      end
      // store in the first free slot if the object fits
      if (req.size <= mdl_free) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && !mdl_valid[i]) begin
            found        = 1'b1;
            mdl_inserts  = mdl_inserts + 32'd1;
            mdl_valid[i] = 1'b1;
            mdl_key[i]   = req.key;
            mdl_bytes[i] = req.size;
            mdl_stamp[i] = mdl_inserts;
            mdl_count++;
            mdl_free     = mdl_free - req.size;
            res.stored   = 1'b1;
            res.slot     = i[SLOT_W-1:0];
          end
        end
      end
    end
    res.evictions  = (n_evict > 31) ? EVICT_MAX : n_evict[EVICT_W-1:0];
    res.free_bytes = mdl_free;
    return res;
  endfunction

  function automatic cache_req_t make_request(logic m, logic [KEY_W-1:0] k,
                                              logic [SIZE_W-1:0] s);
    cache_req_t req;
    req.mode = m;
    req.key  = k;
    req.size = s;
    return req;
  endfunction

  // random item: mostly pool keys so lookups hit and duplicates occur
  function automatic cache_req_t random_request();
    cache_req_t req;
    int         r;
    req.mode = 1'($urandom_range(1, 0));
    if ($urandom_range(99) < ((req.mode == MODE_INSERT) ? 80 : 75))
      req.key = key_pool[$urandom_range(KEY_POOL_SIZE - 1, 0)];
    else
      req.key = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 10)
      req.size = SIZE_W'($urandom);
    else if (r < 18)
      req.size = mdl_max_obj;
    else if (r < 24)
      req.size = (mdl_max_obj == SIZE_MAX) ? SIZE_MAX : mdl_max_obj + 24'd1;
    else if (r < 34)
      req.size = SIZE_W'($urandom_range(3, 0));
    else
      req.size = SIZE_W'($urandom_range(mdl_max_obj, 0));
    return req;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  // register write on an idle block, mirrored in the model
  task automatic write_cache_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [SIZE_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY) begin
      mdl_capacity = data;
      clear_cache_model();
    end else begin
      mdl_max_obj = data;
    end
  endtask

  // sender waits until every item is sent and every result is back,
  // sampled away from the rising edge so driver updates have settled
  task automatic wait_results_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // driver: predict on accept, then offer the next pending item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(predict_cache_result(make_request(mode, key, object_size)));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cache_req_t nxt;
          nxt = pending_reqs.pop_front();
          in_valid    <= 1'b1;
          mode        <= nxt.mode;
          key         <= nxt.key;
          object_size <= nxt.size;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_start) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation waiting");
        failures++;
      end else begin
        want_res = expected_results.pop_front();
        compare_field("hit", 64'(want_res.hit), 64'(hit));
        compare_field("slot", 64'(want_res.slot), 64'(slot));
        compare_field("stored", 64'(want_res.stored), 64'(stored));
        compare_field("evictions", 64'(want_res.evictions), 64'(evictions));
        compare_field("free_bytes", 64'(want_res.free_bytes), 64'(free_bytes));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [SIZE_W-1:0] cap_val;
    logic [SIZE_W-1:0] max_val;

    mdl_capacity = CAP_RESET;
    mdl_max_obj  = MAXOBJ_RESET;
    mdl_inserts  = '0;
    clear_cache_model();
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty lookup, key and size extremes, oversize, duplicates,
    // then fill the table so the next insert evicts the oldest entry
    set_idling(11, 78);
    pending_reqs.push_back(make_request(MODE_LOOKUP, '0, '0));
    pending_reqs.push_back(make_request(MODE_INSERT, '0, '0));
    pending_reqs.push_back(make_request(MODE_INSERT, '1, MAXOBJ_RESET));
    pending_reqs.push_back(make_request(MODE_INSERT, 64'h5a5a, MAXOBJ_RESET + 24'd1));
    pending_reqs.push_back(make_request(MODE_INSERT, 64'h5a5b, SIZE_MAX));
    pending_reqs.push_back(make_request(MODE_LOOKUP, '0, SIZE_MAX));
    pending_reqs.push_back(make_request(MODE_LOOKUP, '1, '0));
    pending_reqs.push_back(make_request(MODE_INSERT, '0, 24'd5));
    pending_reqs.push_back(make_request(MODE_LOOKUP, '0, '0));
    for (int i = 0; i < 13; i++)
      pending_reqs.push_back(make_request(MODE_INSERT, 64'h1000 + i, 24'd1));
    pending_reqs.push_back(make_request(MODE_INSERT, 64'habcd, 24'd7));
    pending_reqs.push_back(make_request(MODE_LOOKUP, '0, '0));
    wait_results_drained();

    // random phases over several budget settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3)
        set_idling(11, 78);
      else if (p < 6)
        set_idling(78, 11);
      else
        set_idling(0, 0);
      case (p)
        0: begin cap_val = CAP_RESET;  max_val = MAXOBJ_RESET; end
        1: begin cap_val = 24'd1;      max_val = SIZE_MAX;     end
        2: begin cap_val = SIZE_MAX;   max_val = 24'd1;        end
        3: begin cap_val = SIZE_MAX;   max_val = SIZE_MAX;     end
        4: begin cap_val = 24'd300000; max_val = 24'd60000;    end
        5: begin cap_val = 24'd50000;  max_val = 24'd102400;   end
        6: begin
          cap_val = SIZE_W'($urandom_range(2000000, 1));
          max_val = SIZE_W'($urandom_range(300000, 1));
        end
        7: begin cap_val = SIZE_MAX;   max_val = 24'd2000000;  end
        default: begin
          cap_val = SIZE_W'($urandom_range(SIZE_MAX, 1));
          max_val = SIZE_W'($urandom_range(cap_val, 1));
        end
      endcase
      write_cache_reg(REG_CAPACITY, cap_val);
      write_cache_reg(REG_MAX_OBJECT, max_val);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mid-phase: drain fully, then tighten the object limit on a live table
        if (p == 4 && n == ITEMS_PER_PHASE / 2) begin
          wait_results_drained();
          write_cache_reg(REG_MAX_OBJECT, 24'd30000);
        end
        pending_reqs.push_back(random_request());
      end
      // long result stall while the sender keeps offering
      if (p == 7) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      wait_results_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bbc_pkg.sv
rtl/core/bbc_entry_mem.sv
rtl/core/bbc_cmp_unit.sv
rtl/core/byte_budget_object_cache_table_unit.sv
test/tb_byte_budget_object_cache_table_unit.sv
